/* rtl/skaf_pkg.sv */
// ----------------------------------------------------------------------------
// skaf_pkg
// Shared widths, register indexes and reset values of the scalar Kalman
// angle filter.
// ----------------------------------------------------------------------------
package skaf_pkg;

  localparam int ANGLE_W = 32;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd2;

  localparam logic [WORD_W-1:0] PROCESS_NOISE_RST = 32'd2684355;
  localparam logic [WORD_W-1:0] MEASURE_NOISE_RST = 32'd107374;
  localparam logic [WORD_W-1:0] STEP_TIME_RST     = 32'd8589935;
  localparam logic [WORD_W-1:0] ERROR_COV_RST     = 32'd268435456;

endpackage

/* rtl/skaf_if.sv */
// ----------------------------------------------------------------------------
// skaf_if
// Request and result channels of the scalar Kalman angle filter.
// ----------------------------------------------------------------------------
interface skaf_in_if import skaf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] measured_angle;
  logic                      measure_ok;
  logic signed [ANGLE_W-1:0] angle_rate;

  modport source (output valid, output measured_angle, output measure_ok,
                  output angle_rate, input ready);
  modport sink   (input valid, input measured_angle, input measure_ok,
                  input angle_rate, output ready);
endinterface

interface skaf_out_if import skaf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

/* rtl/scalar_kalman_angle_filter_core.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_angle_filter_core
// One-state Kalman angle filter with a rate control input. One shared
// 33x33 multiplier and a restoring divider run under a one-hot sequencer.
// ----------------------------------------------------------------------------
// Steps: a full update request runs S_MULS, S_PRED, the 33 steps of the
// one-bit-per-cycle gain divider in S_DIV, S_MULC, S_CORR, S_COV and S_FIN
// (three multiplier passes); a predict-only request goes from S_PRED to S_FIN,
// one before the filter has started straight to S_FIN. Only S_IDLE takes a request.
// Reset: synchronous, clears the estimate, loads P = 1.0 and the default
// noise and step time registers; no clearing pass.
module scalar_kalman_angle_filter_core import skaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  skaf_in_if.sink              sample,
  skaf_out_if.source           result
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MULS = 8'b0000_0010,
    S_PRED = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_MULC = 8'b0001_0000,
    S_CORR = 8'b0010_0000,
    S_COV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  function automatic logic signed [ANGLE_W-1:0] sat34(input logic signed [33:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_t state;

  logic [WORD_W-1:0] process_noise;
  logic [WORD_W-1:0] measure_noise;
  logic [WORD_W-1:0] step_time;

  logic signed [ANGLE_W-1:0] angle_est;
  logic [WORD_W-1:0]         error_cov;
  logic                      started;

  logic signed [ANGLE_W-1:0] z_reg;
  logic                      ok_reg;
  logic signed [ANGLE_W-1:0] u_reg;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_full;
  logic [63:0]        prod;

  logic [WORD_W-1:0] p_reg;
  logic [32:0]       den;
  logic              den_zero;
  logic [33:0]       rem;
  logic [32:0]       quo;
  logic [5:0]        cnt;
  logic              diff_neg;

  logic                      res_valid;
  logic signed [ANGLE_W-1:0] res_data;

  logic signed [63:0]        step_sum;
  logic signed [ANGLE_W-1:0] step;
  logic signed [ANGLE_W-1:0] x_pred;
  logic [32:0]               p_sum;
  logic [WORD_W-1:0]         p_sat;
  logic [32:0]               den_next;
  logic [33:0]               shifted;
  logic                      ge;
  logic [32:0]               k_val;
  logic signed [32:0]        diff;
  logic [32:0]               diff_abs;
  logic [WORD_W-1:0]         mag;
  logic [32:0]               keep;
  logic [64:0]               corr_sum;
  logic [32:0]               corr;
  logic signed [33:0]        corr_res;
  logic [63:0]               cov_sum;
  logic [WORD_W-1:0]         cov_next;
  logic                      accept;
  logic                      fin_go;

  assign accept = sample.valid && sample.ready;
  assign fin_go = (state == S_FIN) && (!res_valid || result.ready);

  assign sample.ready    = (state == S_IDLE);
  assign result.valid    = res_valid;
  assign result.estimate = res_data;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MULS: begin
        mul_a = {u_reg[31], u_reg};
        mul_b = {1'b0, step_time};
      end
      S_MULC: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, k_val[31:0]};
      end
      S_CORR: begin
        mul_a = {1'b0, keep[31:0]};
        mul_b = {1'b0, p_reg};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  assign step_sum = $signed(prod) + 64'sh0000_0000_8000_0000;
  assign step     = $signed(step_sum[63:32]);
  assign x_pred   = sat34({{2{angle_est[31]}}, angle_est} + {{2{step[31]}}, step});

  assign p_sum    = {1'b0, error_cov} + {1'b0, process_noise};
  assign p_sat    = p_sum[32] ? '1 : p_sum[31:0];
  assign den_next = {1'b0, p_sat} + {1'b0, measure_noise};

  assign shifted = (cnt == 6'd0) ? rem : {rem[32:0], 1'b0};
  assign ge      = (shifted >= {1'b0, den});

  assign k_val    = den_zero ? '0 : quo;
  assign diff     = {z_reg[31], z_reg} - {angle_est[31], angle_est};
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign mag      = diff_abs[31:0];
  assign keep     = 33'h1_0000_0000 - k_val;

  assign corr_sum = {1'b0, prod} + 65'h0_8000_0000;
  assign corr     = corr_sum[64:32];
  assign corr_res = diff_neg ? ({{2{angle_est[31]}}, angle_est} - {1'b0, corr})
                             : ({{2{angle_est[31]}}, angle_est} + {1'b0, corr});

  assign cov_sum  = prod + 64'h0000_0000_8000_0000;
  assign cov_next = cov_sum[63:32];

  always_ff @(posedge clk) begin
    prod <= prod_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      step_time     <= STEP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        REG_STEP_TIME:     step_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      angle_est <= '0;
      error_cov <= ERROR_COV_RST;
      started   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            z_reg  <= sample.measured_angle;
            ok_reg <= sample.measure_ok;
            u_reg  <= sample.angle_rate;
            if (!started) begin
              if (sample.measure_ok) begin
                angle_est <= sample.measured_angle;
                started   <= 1'b1;
              end
              state <= S_FIN;
            end else begin
              state <= S_MULS;
            end
          end
        end
        S_MULS: begin
          state <= S_PRED;
        end
        S_PRED: begin
          angle_est <= x_pred;
          if (!ok_reg) begin
            state <= S_FIN;
          end else begin
            p_reg    <= p_sat;
            den      <= den_next;
            den_zero <= (den_next == '0);
            rem      <= {2'b00, p_sat};
            quo      <= '0;
            cnt      <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? (shifted - {1'b0, den}) : shifted;
          quo <= {quo[31:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            state <= S_MULC;
          end
        end
        S_MULC: begin
          diff_neg <= diff[32];
          state    <= S_CORR;
        end
        S_CORR: begin
          if (k_val[32]) begin
            angle_est <= z_reg;
          end else begin
            angle_est <= sat34(corr_res);
          end
          state <= S_COV;
        end
        S_COV: begin
          if (k_val[32]) begin
            error_cov <= '0;
          end else if (k_val == '0) begin
            error_cov <= p_reg;
          end else begin
            error_cov <= cov_next;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_go) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_data <= angle_est;
    end
  end

endmodule

/* rtl/skaf_checker.sv */
// ----------------------------------------------------------------------------
// skaf_checker
// Port-level checks of the scalar Kalman angle filter, bound to the core.
// ----------------------------------------------------------------------------
module skaf_checker import skaf_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [ANGLE_W-1:0] estimate
);

  logic [1:0] owed;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (owed != 2'd0))
    else $error("result without an outstanding request");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(estimate))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_angle_filter_core skaf_checker u_skaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .estimate  (result.estimate)
);
